// File: sv/axis_angle_rotation_matrix_assert.svh
// Assertion macros shared by the rotation-matrix RTL.
// Each macro expects clk and rst_n in scope and reports through $error.
`ifndef AXIS_ANGLE_ROTATION_MATRIX_ASSERT_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_ASSERT_SVH

// Property checked at every clock edge outside reset
`define AARM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define AARM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define AARM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/aarm_pkg.sv
`default_nettype none
// Package for the rotation-matrix block: transfer types, fixed-point constants
// and the CORDIC arctangent table. No dependencies.
package aarm_pkg;

    localparam int TRIG_ITERATIONS_DEF = 16;
    localparam int ATAN_ENTRIES        = 24;
    localparam int QUEUE_DEPTH_DEF     = 4;

    localparam int FULL_TURN    = 23040;
    localparam int HALF_TURN    = 11520;
    localparam int QUARTER_TURN = 5760;

    typedef logic signed [33:0] cordic_t;
    typedef logic signed [21:0] q20_t;
    typedef logic signed [22:0] omc_t;
    typedef logic signed [43:0] ns_t;
    typedef logic signed [45:0] p_t;
    typedef logic signed [47:0] v_t;

    localparam cordic_t UNIT_TO_RAD_Q30 = 34'sd292818;
    localparam cordic_t CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam cordic_t CS_HALF         = 34'sd512;
    localparam ns_t     NN_HALF         = 44'sd524288;
    localparam v_t      Q14_HALF        = 48'sd33554432;
    localparam v_t      Q14_MAX         = 48'sd16384;
    localparam omc_t    ONE_Q20         = 23'sd1048576;
    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

    typedef struct packed {
        logic signed [15:0] angle_deg;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
    } item_t;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
        logic               axis_zero;
    } result_t;

    // Classified item handed from the front end to the back end
    typedef struct packed {
        logic               zero;
        logic               cneg;
        cordic_t            z0;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic [31:0]        sum;
    } front_t;

    function automatic cordic_t atan_q30(input logic [4:0] idx);
        cordic_t a;
        case (idx)
            5'd0:    a = 34'sd843314856;
            5'd1:    a = 34'sd497837829;
            5'd2:    a = 34'sd263043836;
            5'd3:    a = 34'sd133525158;
            5'd4:    a = 34'sd67021686;
            5'd5:    a = 34'sd33543515;
            5'd6:    a = 34'sd16775850;
            5'd7:    a = 34'sd8388437;
            5'd8:    a = 34'sd4194282;
            5'd9:    a = 34'sd2097149;
            5'd10:   a = 34'sd1048575;
            5'd11:   a = 34'sd524287;
            5'd12:   a = 34'sd262143;
            5'd13:   a = 34'sd131071;
            5'd14:   a = 34'sd65535;
            5'd15:   a = 34'sd32767;
            5'd16:   a = 34'sd16383;
            5'd17:   a = 34'sd8191;
            5'd18:   a = 34'sd4095;
            5'd19:   a = 34'sd2047;
            5'd20:   a = 34'sd1023;
            5'd21:   a = 34'sd511;
            5'd22:   a = 34'sd255;
            5'd23:   a = 34'sd127;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

// File: sv/aarm_front.sv
`default_nettype none
// Front end: reduces the angle to a quarter turn, squares the axis and flags a zero axis.
// Two register stages; depends on aarm_pkg.
module aarm_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire aarm_pkg::item_t  item,
    output logic                  q_push,
    output aarm_pkg::front_t      q_data,
    input  wire logic             q_full
);
    import aarm_pkg::*;

    localparam logic signed [16:0] FULL_A    = 17'(FULL_TURN);
    localparam logic signed [16:0] HALF_A    = 17'(HALF_TURN);
    localparam logic signed [16:0] QUARTER_A = 17'(QUARTER_TURN);

    logic               adv;
    logic               f1_valid_reg;
    logic               f2_valid_reg;
    logic signed [16:0] a_wrap;
    logic signed [16:0] a_pos;
    logic signed [16:0] a_half;
    logic signed [13:0] r_next;
    logic               cneg_next;
    logic signed [31:0] sqx;
    logic signed [31:0] sqy;
    logic signed [31:0] sqz;
    logic [30:0]        sq_reg [3];
    logic signed [13:0] r_reg;
    logic               cneg_reg;
    logic               zero_reg;
    logic signed [15:0] ax_reg;
    logic signed [15:0] ay_reg;
    logic signed [15:0] az_reg;
    cordic_t            r_wide;
    front_t             f2_next;
    front_t             f2_reg;

    // Fold the angle into [-90, +90] degrees, noting when cosine changes sign
    always_comb
    begin
        a_wrap = 17'(item.angle_deg);
        if (a_wrap >= FULL_A)
        begin
            a_wrap = a_wrap - FULL_A;
        end
        else if (a_wrap <= -FULL_A)
        begin
            a_wrap = a_wrap + FULL_A;
        end
        a_pos  = a_wrap[16] ? a_wrap + FULL_A : a_wrap;
        a_half = (a_pos >= HALF_A) ? a_pos - FULL_A : a_pos;
        cneg_next = 1'b0;
        if (a_half > QUARTER_A)
        begin
            r_next    = 14'(HALF_A - a_half);
            cneg_next = 1'b1;
        end
        else if (a_half < -QUARTER_A)
        begin
            r_next    = 14'(-HALF_A - a_half);
            cneg_next = 1'b1;
        end
        else
        begin
            r_next = 14'(a_half);
        end
        sqx = item.axis_x * item.axis_x;
        sqy = item.axis_y * item.axis_y;
        sqz = item.axis_z * item.axis_z;
    end

    always_comb
    begin
        r_wide         = cordic_t'(r_reg);
        f2_next.zero   = zero_reg;
        f2_next.cneg   = cneg_reg;
        f2_next.z0     = r_wide * UNIT_TO_RAD_Q30;
        f2_next.axis_x = ax_reg;
        f2_next.axis_y = ay_reg;
        f2_next.axis_z = az_reg;
        f2_next.sum    = 32'(sq_reg[0]) + 32'(sq_reg[1]) + 32'(sq_reg[2]);
    end

    assign adv        = !f2_valid_reg || !q_full;
    assign item_stall = !adv;
    assign q_push     = f2_valid_reg && !q_full;
    assign q_data     = f2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_valid_reg <= item_valid;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg[0] <= sqx[30:0];
            sq_reg[1] <= sqy[30:0];
            sq_reg[2] <= sqz[30:0];
            r_reg     <= r_next;
            cneg_reg  <= cneg_next;
            zero_reg  <= (item.axis_x == '0) && (item.axis_y == '0) && (item.axis_z == '0);
            ax_reg    <= item.axis_x;
            ay_reg    <= item.axis_y;
            az_reg    <= item.axis_z;
            f2_reg    <= f2_next;
        end
    end

endmodule
`default_nettype wire

// File: sv/aarm_queue.sv
`default_nettype none
`include "axis_angle_rotation_matrix_assert.svh"
// Short register queue between front end and back end.
// Depends on aarm_pkg for the entry type.
module aarm_queue #(
    parameter int DEPTH = aarm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire aarm_pkg::front_t  push_data,
    output logic                   full,
    input  wire logic              pop,
    output aarm_pkg::front_t       pop_data,
    output logic                   empty
);
    import aarm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    front_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `AARM_ASSERT_IMPL(a_no_overflow, push, !full, "queue written while full")
    `AARM_ASSERT_IMPL(a_no_underflow, pop, !empty, "queue read while empty")
    `AARM_ASSERT_ALWAYS(a_count_max, count_reg <= CNT_W'(DEPTH), "queue count beyond depth")
    `AARM_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count did not rise")

endmodule
`default_nettype wire

// File: sv/aarm_back.sv
`default_nettype none
`include "axis_angle_rotation_matrix_assert.svh"
// Back end: pipelined square root and CORDIC, bit-per-stage dividers, matrix assembly.
// The whole pipe advances when the output register is free; depends on aarm_pkg.
module aarm_back #(
    parameter int TRIG_ITERATIONS = aarm_pkg::TRIG_ITERATIONS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire aarm_pkg::front_t  head,
    input  wire logic              head_valid,
    output logic                   head_pop,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output aarm_pkg::result_t      result
);
    import aarm_pkg::*;

    localparam int ITER_EFF   = (TRIG_ITERATIONS < ATAN_ENTRIES) ? TRIG_ITERATIONS : ATAN_ENTRIES;
    localparam int SQRT_STEPS = 32;
    localparam int SQ_W       = 63;
    localparam int ROOT_W     = 32;
    localparam int QUOT_BITS  = 21;
    localparam int DIV_W      = 52;

    typedef struct packed {
        logic               zero;
        logic               cneg;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic [SQ_W-1:0]    rem;
        logic [SQ_W-1:0]    res;
        cordic_t            x;
        cordic_t            y;
        cordic_t            z;
    } sq_t;

    typedef struct packed {
        logic                            zero;
        logic                            cneg;
        logic [2:0]                      neg;
        logic [ROOT_W-1:0]               root;
        logic [2:0][DIV_W-1:0]           rem;
        logic [2:0][QUOT_BITS-1:0]       q;
        q20_t                            c;
        q20_t                            s;
    } dv_t;

    typedef struct packed {
        logic zero;
        q20_t n0;
        q20_t n1;
        q20_t n2;
        q20_t c;
        q20_t s;
        omc_t omc;
    } c0_t;

    typedef struct packed {
        logic zero;
        q20_t nn00;
        q20_t nn01;
        q20_t nn02;
        q20_t nn11;
        q20_t nn12;
        q20_t nn22;
        ns_t  ns0;
        ns_t  ns1;
        ns_t  ns2;
        omc_t omc;
        q20_t c;
    } c1_t;

    typedef struct packed {
        logic zero;
        p_t   p00;
        p_t   p01;
        p_t   p02;
        p_t   p11;
        p_t   p12;
        p_t   p22;
        ns_t  ns0;
        ns_t  ns1;
        ns_t  ns2;
        q20_t c;
    } c2_t;

    logic                  adv;
    logic [SQRT_STEPS-1:0] a_valid_reg;
    logic [QUOT_BITS-1:0]  b_valid_reg;
    logic [3:0]            c_valid_reg;
    sq_t                   a_src [SQRT_STEPS];
    sq_t                   a_reg [SQRT_STEPS];
    sq_t                   a_init;
    sq_t                   a_last;
    dv_t                   b_src [QUOT_BITS];
    dv_t                   b_reg [QUOT_BITS];
    dv_t                   b_init;
    dv_t                   b_last;
    logic [15:0]           mag [3];
    logic signed [15:0]    axv [3];
    cordic_t               cx_round;
    cordic_t               cy_round;
    c0_t                   c0_next;
    c0_t                   c0_reg;
    c1_t                   c1_next;
    c1_t                   c1_reg;
    c2_t                   c2_next;
    c2_t                   c2_reg;
    q20_t                  c_fin;
    v_t                    cd;
    v_t                    v00;
    v_t                    v01;
    v_t                    v02;
    v_t                    v10;
    v_t                    v11;
    v_t                    v12;
    v_t                    v20;
    v_t                    v21;
    v_t                    v22;
    ns_t                   pr00;
    ns_t                   pr01;
    ns_t                   pr02;
    ns_t                   pr11;
    ns_t                   pr12;
    ns_t                   pr22;
    result_t               result_next;
    result_t               result_reg;

    // One root bit and, for steps below ITER_EFF, one CORDIC micro-rotation
    function automatic sq_t sq_step(input sq_t p, input int s);
        sq_t             o;
        logic [SQ_W-1:0] bitv;
        logic [SQ_W-1:0] trial;
        cordic_t         xv;
        cordic_t         yv;
        o     = p;
        xv    = p.x;
        yv    = p.y;
        bitv  = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - s));
        trial = p.res + bitv;
        if (p.rem >= trial)
        begin
            o.rem = p.rem - trial;
            o.res = (p.res >> 1) + bitv;
        end
        else
        begin
            o.res = p.res >> 1;
        end
        if (s < ITER_EFF)
        begin
            if (!p.z[33])
            begin
                o.x = xv - (yv >>> s);
                o.y = yv + (xv >>> s);
                o.z = p.z - atan_q30(5'(s));
            end
            else
            begin
                o.x = xv + (yv >>> s);
                o.y = yv - (xv >>> s);
                o.z = p.z + atan_q30(5'(s));
            end
        end
        return o;
    endfunction

    // One quotient bit for each of the three axis dividers
    function automatic dv_t dv_step(input dv_t p, input int k);
        dv_t              o;
        logic [DIV_W-1:0] sh;
        o  = p;
        sh = DIV_W'(p.root) << k;
        for (int i = 0; i < 3; i++)
        begin
            if (p.rem[i] >= sh)
            begin
                o.rem[i]  = p.rem[i] - sh;
                o.q[i][k] = 1'b1;
            end
        end
        return o;
    endfunction

    function automatic q20_t signed_q(input logic neg, input logic [QUOT_BITS-1:0] q);
        q20_t t;
        t = q20_t'({1'b0, q});
        return neg ? -t : t;
    endfunction

    function automatic q20_t rnd20(input ns_t v);
        ns_t t;
        t = (v + NN_HALF) >>> 20;
        return q20_t'(t[21:0]);
    endfunction

    function automatic logic signed [15:0] to_q14(input v_t v);
        v_t t;
        t = (v + Q14_HALF) >>> 26;
        if (t > Q14_MAX)
        begin
            return ONE_Q14;
        end
        if (t < -Q14_MAX)
        begin
            return -ONE_Q14;
        end
        return t[15:0];
    endfunction

    assign adv          = !c_valid_reg[3] || !result_stall;
    assign head_pop     = adv && head_valid;
    assign result_valid = c_valid_reg[3];
    assign result       = result_reg;

    always_comb
    begin
        a_init.zero = head.zero;
        a_init.cneg = head.cneg;
        a_init.ax   = head.axis_x;
        a_init.ay   = head.axis_y;
        a_init.az   = head.axis_z;
        a_init.rem  = SQ_W'(head.sum) << 30;
        a_init.res  = '0;
        a_init.x    = CORDIC_GAIN_Q30;
        a_init.y    = '0;
        a_init.z    = head.z0;
    end

    for (genvar s = 0; s < SQRT_STEPS; s++)
    begin : g_sqrt
        if (s == 0)
        begin : g_head
            assign a_src[s] = a_init;
        end
        else
        begin : g_chain
            assign a_src[s] = a_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                a_reg[s] <= sq_step(a_src[s], s);
            end
        end
    end

    // Start the dividers: numerator is |a| * 2^35 plus half the root
    always_comb
    begin
        a_last = a_reg[SQRT_STEPS-1];
        axv[0] = a_last.ax;
        axv[1] = a_last.ay;
        axv[2] = a_last.az;
        b_init.zero = a_last.zero;
        b_init.cneg = a_last.cneg;
        b_init.root = a_last.res[ROOT_W-1:0];
        b_init.q    = '0;
        for (int i = 0; i < 3; i++)
        begin
            b_init.neg[i] = axv[i][15];
            mag[i]        = axv[i][15] ? 16'(-axv[i]) : 16'(axv[i]);
            b_init.rem[i] = (DIV_W'(mag[i]) << 35) + DIV_W'(a_last.res[ROOT_W-1:0] >> 1);
        end
        cx_round = (a_last.x + CS_HALF) >>> 10;
        cy_round = (a_last.y + CS_HALF) >>> 10;
        b_init.c = q20_t'(cx_round[21:0]);
        b_init.s = q20_t'(cy_round[21:0]);
    end

    for (genvar j = 0; j < QUOT_BITS; j++)
    begin : g_div
        if (j == 0)
        begin : g_head
            assign b_src[j] = b_init;
        end
        else
        begin : g_chain
            assign b_src[j] = b_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                b_reg[j] <= dv_step(b_src[j], QUOT_BITS - 1 - j);
            end
        end
    end

    always_comb
    begin
        b_last      = b_reg[QUOT_BITS-1];
        c_fin       = b_last.cneg ? -b_last.c : b_last.c;
        c0_next.zero = b_last.zero;
        c0_next.n0  = signed_q(b_last.neg[0], b_last.q[0]);
        c0_next.n1  = signed_q(b_last.neg[1], b_last.q[1]);
        c0_next.n2  = signed_q(b_last.neg[2], b_last.q[2]);
        c0_next.c   = c_fin;
        c0_next.s   = b_last.s;
        c0_next.omc = ONE_Q20 - c_fin;
    end

    always_comb
    begin
        pr00 = c0_reg.n0 * c0_reg.n0;
        pr01 = c0_reg.n0 * c0_reg.n1;
        pr02 = c0_reg.n0 * c0_reg.n2;
        pr11 = c0_reg.n1 * c0_reg.n1;
        pr12 = c0_reg.n1 * c0_reg.n2;
        pr22 = c0_reg.n2 * c0_reg.n2;
        c1_next.zero = c0_reg.zero;
        c1_next.nn00 = rnd20(pr00);
        c1_next.nn01 = rnd20(pr01);
        c1_next.nn02 = rnd20(pr02);
        c1_next.nn11 = rnd20(pr11);
        c1_next.nn12 = rnd20(pr12);
        c1_next.nn22 = rnd20(pr22);
        c1_next.ns0  = c0_reg.n0 * c0_reg.s;
        c1_next.ns1  = c0_reg.n1 * c0_reg.s;
        c1_next.ns2  = c0_reg.n2 * c0_reg.s;
        c1_next.omc  = c0_reg.omc;
        c1_next.c    = c0_reg.c;
    end

    always_comb
    begin
        c2_next.zero = c1_reg.zero;
        c2_next.p00  = c1_reg.nn00 * c1_reg.omc;
        c2_next.p01  = c1_reg.nn01 * c1_reg.omc;
        c2_next.p02  = c1_reg.nn02 * c1_reg.omc;
        c2_next.p11  = c1_reg.nn11 * c1_reg.omc;
        c2_next.p12  = c1_reg.nn12 * c1_reg.omc;
        c2_next.p22  = c1_reg.nn22 * c1_reg.omc;
        c2_next.ns0  = c1_reg.ns0;
        c2_next.ns1  = c1_reg.ns1;
        c2_next.ns2  = c1_reg.ns2;
        c2_next.c    = c1_reg.c;
    end

    // Symmetric part plus skew part; cosine on the diagonal; identity for a zero axis
    always_comb
    begin
        cd  = c2_reg.c;
        cd  = cd <<< 20;
        v00 = c2_reg.p00 + cd;
        v01 = c2_reg.p01 - c2_reg.ns2;
        v02 = c2_reg.p02 + c2_reg.ns1;
        v10 = c2_reg.p01 + c2_reg.ns2;
        v11 = c2_reg.p11 + cd;
        v12 = c2_reg.p12 - c2_reg.ns0;
        v20 = c2_reg.p02 - c2_reg.ns1;
        v21 = c2_reg.p12 + c2_reg.ns0;
        v22 = c2_reg.p22 + cd;
        if (c2_reg.zero)
        begin
            result_next.m00       = ONE_Q14;
            result_next.m01       = '0;
            result_next.m02       = '0;
            result_next.m10       = '0;
            result_next.m11       = ONE_Q14;
            result_next.m12       = '0;
            result_next.m20       = '0;
            result_next.m21       = '0;
            result_next.m22       = ONE_Q14;
            result_next.axis_zero = 1'b1;
        end
        else
        begin
            result_next.m00       = to_q14(v00);
            result_next.m01       = to_q14(v01);
            result_next.m02       = to_q14(v02);
            result_next.m10       = to_q14(v10);
            result_next.m11       = to_q14(v11);
            result_next.m12       = to_q14(v12);
            result_next.m20       = to_q14(v20);
            result_next.m21       = to_q14(v21);
            result_next.m22       = to_q14(v22);
            result_next.axis_zero = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c0_reg     <= c0_next;
            c1_reg     <= c1_next;
            c2_reg     <= c2_next;
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= '0;
            b_valid_reg <= '0;
            c_valid_reg <= '0;
        end
        else if (adv)
        begin
            a_valid_reg <= {a_valid_reg[SQRT_STEPS-2:0], head_valid};
            b_valid_reg <= {b_valid_reg[QUOT_BITS-2:0], a_valid_reg[SQRT_STEPS-1]};
            c_valid_reg <= {c_valid_reg[2:0], b_valid_reg[QUOT_BITS-1]};
        end
    end

    `AARM_ASSERT_IMPL(a_zero_ident, result_valid && result.axis_zero, result.m00 == ONE_Q14 && result.m11 == ONE_Q14 && result.m22 == ONE_Q14 && result.m01 == 16'sd0, "zero axis without identity")
    `AARM_ASSERT_IMPL(a_sat_range, result_valid, result.m01 <= ONE_Q14 && result.m01 >= -ONE_Q14 && result.m12 <= ONE_Q14 && result.m12 >= -ONE_Q14, "entry beyond saturation")
    `AARM_ASSERT_NEXT(a_pop_enters, head_pop, a_valid_reg[0], "popped item missing from pipe")

endmodule
`default_nettype wire

// File: sv/axis_angle_rotation_matrix.sv
// Rotation matrix from angle and axis (Rodrigues), Q2.14 entries.
// A result passes through the front end, the queue, the 32-stage root pipe, the 21-stage divider
// pipe and the matrix stages; throughput: one item per cycle while the result is not stalled.
// A stalled result holds the back end; front end and queue keep taking items until full.
// Reset (rst_n low, asynchronous) empties the pipe and the queue.
`default_nettype none
module axis_angle_rotation_matrix #(
    parameter int TRIG_ITERATIONS = aarm_pkg::TRIG_ITERATIONS_DEF,
    parameter int QUEUE_DEPTH     = aarm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire aarm_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output aarm_pkg::result_t      result
);
    import aarm_pkg::*;

    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_empty;
    front_t q_in;
    front_t q_out;

    aarm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_push     (q_push),
        .q_data     (q_in),
        .q_full     (q_full)
    );

    aarm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    aarm_back #(
        .TRIG_ITERATIONS (TRIG_ITERATIONS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_out),
        .head_valid   (!q_empty),
        .head_pop     (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
`default_nettype wire

// File: tb/tb_axis_angle_rotation_matrix.sv
// Testbench for axis_angle_rotation_matrix: directed and random axis-angle transfers
// checked against a bit-exact Rodrigues/CORDIC predictor. Depends on aarm_pkg.
module tb_axis_angle_rotation_matrix;
    import aarm_pkg::*;

    localparam int ITERS      = TRIG_ITERATIONS_DEF;
    localparam int CYCLE_CAP  = 600000;
    localparam int DRAIN_WAIT = 150;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    result_t matrix_q[$];
    int      n_errors;
    int      cycles;
    bit      quiet;
    int      stall_left;

    longint atan_tab[24] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767, 16383, 8191,
        4095, 2047, 1023, 511, 255, 127};

    axis_angle_rotation_matrix u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("tb_axis_angle_rotation_matrix: done, errors");
            $finish;
        end
    end

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint unit_axis(longint a, longint unsigned root);
        longint unsigned mag;
        longint unsigned q;
        mag = (a < 0) ? -a : a;
        q = ((mag << 35) + (root >> 1)) / root;
        return (a < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic result_t rodrigues(item_t it);
        longint ang, ax, ay, az, r, x, y, z, dx, dy, c, s, omc, nn, v;
        longint unsigned sum, root;
        longint n[3];
        longint sk[3][3];
        logic signed [15:0] m[9];
        bit cneg;
        result_t res;
        ang = it.angle_deg;
        ax = it.axis_x;
        ay = it.axis_y;
        az = it.axis_z;
        sum = ax * ax + ay * ay + az * az;
        res = '0;
        if (sum == 0)
        begin
            res.m00 = ONE_Q14;
            res.m11 = ONE_Q14;
            res.m22 = ONE_Q14;
            res.axis_zero = 1'b1;
            return res;
        end
        // fold the angle into a quarter turn either side of zero
        r = ang % FULL_TURN;
        cneg = 0;
        if (r < 0)
            r += FULL_TURN;
        if (r >= HALF_TURN)
            r -= FULL_TURN;
        if (r > QUARTER_TURN)
        begin
            r = HALF_TURN - r;
            cneg = 1;
        end
        else if (r < -QUARTER_TURN)
        begin
            r = -HALF_TURN - r;
            cneg = 1;
        end
        x = 652032874;
        y = 0;
        z = r * 292818;
        for (int i = 0; i < ITERS && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= atan_tab[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += atan_tab[i];
            end
        end
        c = (x + 512) >>> 10;
        s = (y + 512) >>> 10;
        if (cneg)
            c = -c;
        omc = (64'sd1 <<< 20) - c;
        root = root64(sum << 30);
        n[0] = unit_axis(ax, root);
        n[1] = unit_axis(ay, root);
        n[2] = unit_axis(az, root);
        sk[0][0] = 0;     sk[0][1] = -n[2]; sk[0][2] = n[1];
        sk[1][0] = n[2];  sk[1][1] = 0;     sk[1][2] = -n[0];
        sk[2][0] = -n[1]; sk[2][1] = n[0];  sk[2][2] = 0;
        for (int row = 0; row < 3; row++)
        begin
            for (int col = 0; col < 3; col++)
            begin
                nn = (n[row] * n[col] + (64'sd1 <<< 19)) >>> 20;
                v = nn * omc + sk[row][col] * s;
                if (row == col)
                    v += c <<< 20;
                v = (v + (64'sd1 <<< 25)) >>> 26;
                if (v > 16384)
                    v = 16384;
                if (v < -16384)
                    v = -16384;
                m[row * 3 + col] = v[15:0];
            end
        end
        res.m00 = m[0]; res.m01 = m[1]; res.m02 = m[2];
        res.m10 = m[3]; res.m11 = m[4]; res.m12 = m[5];
        res.m20 = m[6]; res.m21 = m[7]; res.m22 = m[8];
        res.axis_zero = 1'b0;
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result-side stall: bursts of random length, none in quiet stretches
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            result_stall = 1'b1;
            stall_left--;
        end
        else
        begin
            result_stall = 1'b0;
            if ($urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            n_errors++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (matrix_q.size() == 0)
            begin
                $error("result transfer with no matrix pending");
                n_errors++;
            end
            else
            begin
                want = matrix_q.pop_front();
                check_field("m00", want.m00, result.m00);
                check_field("m01", want.m01, result.m01);
                check_field("m02", want.m02, result.m02);
                check_field("m10", want.m10, result.m10);
                check_field("m11", want.m11, result.m11);
                check_field("m12", want.m12, result.m12);
                check_field("m20", want.m20, result.m20);
                check_field("m21", want.m21, result.m21);
                check_field("m22", want.m22, result.m22);
                check_field("axis_zero", 16'(want.axis_zero), 16'(result.axis_zero));
            end
        end
    end

    // hold the item until it is taken, then queue its matrix
    task automatic send_item(logic signed [15:0] ang, logic signed [15:0] x,
                             logic signed [15:0] y, logic signed [15:0] z);
        int gap;
        item_t it;
        gap = pick_gap();
        it.angle_deg = ang;
        it.axis_x = x;
        it.axis_y = y;
        it.axis_z = z;
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item = it;
        item_valid = 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        matrix_q.push_back(rodrigues(it));
    endtask

    function automatic logic signed [15:0] rand_axis();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 6) - 3);
            1: return 16'sh8000;
            2: return 16'sh7fff;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic signed [15:0] rand_angle();
        if ($urandom_range(0, 9) == 0)
            return 16'($urandom_range(0, 65535));
        return 16'($signed($urandom_range(0, 2 * FULL_TURN)) - FULL_TURN);
    endfunction

    task automatic test_angle_edges();
        logic signed [15:0] angs[14] = '{0, 23040, -23040, 5760, -5760, 5761, -5761,
                                          11520, -11520, 11519, 1, -1, 32767, -32768};
        foreach (angs[i])
            send_item(angs[i], 16'sd100, -16'sd200, 16'sd300);
    endtask

    task automatic test_axis_edges();
        send_item(16'sd2880, 16'sd0, 16'sd0, 16'sd0);
        send_item(-16'sd23040, 16'sd0, 16'sd0, 16'sd0);
        send_item(16'sd5760, 16'sd1, 16'sd0, 16'sd0);
        send_item(16'sd5760, 16'sd0, -16'sd1, 16'sd0);
        send_item(16'sd1920, 16'sd0, 16'sd0, 16'sh7fff);
        send_item(16'sd1920, 16'sh8000, 16'sh8000, 16'sh8000);
        send_item(-16'sd7000, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_item(16'sd11520, 16'sh8000, 16'sh7fff, 16'sd1);
        send_item(16'sd4000, -16'sd1, -16'sd1, -16'sd1);
    endtask

    task automatic test_random(int count);
        for (int k = 0; k < count; k++)
        begin
            if (k % 120 == 0)
                quiet = ($urandom_range(0, 2) == 0);
            if (k == count / 2)
            begin
                // drop valid so the last transfer is not taken again while draining
                @(negedge clk);
                item_valid = 1'b0;
                wait (matrix_q.size() == 0);
            end
            if ($urandom_range(0, 29) == 0)
                send_item(rand_angle(), 16'sd0, 16'sd0, 16'sd0);
            else
                send_item(rand_angle(), rand_axis(), rand_axis(), rand_axis());
        end
        quiet = 0;
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_stall = 1'b0;
        stall_left = 0;
        n_errors = 0;
        cycles = 0;
        quiet = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_angle_edges();
        test_axis_edges();
        test_random(530);

        @(negedge clk);
        item_valid = 1'b0;
        wait (matrix_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (n_errors == 0 && matrix_q.size() == 0)
            $display("tb_axis_angle_rotation_matrix: done, clean");
        else
            $display("tb_axis_angle_rotation_matrix: done, errors");
        $finish;
    end
endmodule
